// File: rtl/core/atrp_pkg.sv
package atrp_pkg;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_TOKEN  = 3'd1;
    localparam logic [2:0] KIND_ROW    = 3'd2;
    localparam logic [2:0] KIND_DONE   = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    localparam logic [3:0] ERR_MAGIC     = 4'd0;
    localparam logic [3:0] ERR_MISSING   = 4'd1;
    localparam logic [3:0] ERR_BAD_DIGIT = 4'd2;
    localparam logic [3:0] ERR_TOO_LARGE = 4'd3;
    localparam logic [3:0] ERR_ROWS      = 4'd4;
    localparam logic [3:0] ERR_STATE     = 4'd5;
    localparam logic [3:0] ERR_MINUS     = 4'd6;
    localparam logic [3:0] ERR_MINUS_TAB = 4'd7;
    localparam logic [3:0] ERR_TAPE      = 4'd8;
    localparam logic [3:0] ERR_END_TOKEN = 4'd9;
    localparam logic [3:0] ERR_NEWLINE   = 4'd10;
    localparam logic [3:0] ERR_EMPTY_TOK = 4'd11;

    // character classes produced by the front end
    localparam logic [2:0] CLS_DIGIT   = 3'd0;
    localparam logic [2:0] CLS_TAB     = 3'd1;
    localparam logic [2:0] CLS_NEWLINE = 3'd2;
    localparam logic [2:0] CLS_MINUS   = 3'd3;
    localparam logic [2:0] CLS_END     = 3'd4;
    localparam logic [2:0] CLS_OTHER   = 3'd5;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam int MAGIC_LEN = 7;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h49;
            3'd1:    c = 8'h4e;
            3'd2:    c = 8'h52;
            3'd3:    c = 8'h32;
            3'd4:    c = 8'h31;
            3'd5:    c = 8'h30;
            3'd6:    c = CH_TAB;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] cls;
        logic [3:0] digit;
    } atrp_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [14:0] count_tapes;
        logic [14:0] count_rows;
        logic [14:0] count_states;
        logic [14:0] count_symbols;
        logic [14:0] src_state;
        logic [14:0] dst_state;
        logic [15:0] tape_index;
        logic [14:0] token_length;
        logic [15:0] label_value;
        logic [7:0]  token_byte;
        logic [3:0]  fault_code;
    } atrp_result_t;

endpackage

// File: rtl/core/atrp_front.sv
module atrp_front
    import atrp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       is_end,
    output logic       word_valid,
    input  logic       word_take,
    output atrp_word_t word
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    atrp_word_t        mem_reg [DEPTH];
    logic [AW-1:0]     wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]       cnt_reg, cnt_next;
    atrp_word_t        cls_w;
    logic              do_push, do_pop;

    // classify the incoming byte
    always_comb
    begin
        cls_w.ch    = in_byte;
        cls_w.digit = 4'(in_byte - CH_ZERO);
        if (is_end)
            cls_w.cls = CLS_END;
        else if (in_byte >= CH_ZERO && in_byte <= CH_NINE)
            cls_w.cls = CLS_DIGIT;
        else if (in_byte == CH_TAB)
            cls_w.cls = CLS_TAB;
        else if (in_byte == CH_NEWLINE)
            cls_w.cls = CLS_NEWLINE;
        else if (in_byte == CH_MINUS)
            cls_w.cls = CLS_MINUS;
        else
            cls_w.cls = CLS_OTHER;
    end

    assign full       = (cnt_reg == (AW+1)'(DEPTH));
    assign word_valid = (cnt_reg != '0);
    assign word       = mem_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = word_take && word_valid;

    // queue pointers
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= cls_w;
    end

endmodule

// File: rtl/core/atrp_back.sv
module atrp_back
    import atrp_pkg::*;
#(
    parameter int FIELD_MAX = 32767
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         word_valid,
    output logic         word_take,
    input  atrp_word_t   word,
    output logic         empty,
    input  logic         pop,
    output atrp_result_t res
);

    localparam int VW = $clog2(FIELD_MAX + 1);

    localparam logic [4:0] PH_MAGIC    = 5'd0;
    localparam logic [4:0] PH_NUM      = 5'd7;
    localparam logic [4:0] PH_ROWFIRST = 5'd23;
    localparam logic [4:0] PH_ROWNEXT  = 5'd24;
    localparam logic [4:0] PH_MINUS1   = 5'd25;
    localparam logic [4:0] PH_MINUSTAB = 5'd26;
    localparam logic [4:0] PH_TOKEN    = 5'd27;
    localparam logic [4:0] PH_NEWLINE  = 5'd28;
    localparam logic [4:0] PH_ABSORB   = 5'd29;

    localparam logic [2:0] F_TAPES  = 3'd0;
    localparam logic [2:0] F_ROWS   = 3'd1;
    localparam logic [2:0] F_STATES = 3'd2;
    localparam logic [2:0] F_SYMS   = 3'd3;
    localparam logic [2:0] F_FROM   = 3'd4;
    localparam logic [2:0] F_TO     = 3'd5;
    localparam logic [2:0] F_TAPE   = 3'd6;

    logic [4:0]    phase_reg, phase_next;
    logic [VW-1:0] acc_reg, acc_next;
    logic [VW-1:0] tapes_reg, tapes_next, rows_reg, rows_next;
    logic [VW-1:0] states_reg, states_next, syms_reg, syms_next;
    logic [VW-1:0] seen_reg, seen_next, from_reg, from_next, to_reg, to_next;
    logic [VW-1:0] len_reg, len_next, left_reg, left_next;
    logic [VW-1:0] tape_reg, tape_next;
    logic          none_reg, none_next;
    logic          full_reg;
    atrp_result_t  res_reg, r;
    logic          emit, is_err, do_clear, step;
    logic [3:0]    err;
    logic [4:0]    k;
    logic [2:0]    f;
    logic          first, is_dig, is_term;
    logic [VW+3:0] prod;
    logic [VW-1:0] v;
    logic [15:0]   label;

    assign empty     = !full_reg;
    assign res       = res_reg;
    assign word_take = !full_reg || pop;
    assign step      = word_valid && word_take;

    assign k      = phase_reg - PH_NUM;
    assign f      = k[3:1];
    assign first  = !k[0];
    assign is_dig = (word.cls == CLS_DIGIT);
    assign prod   = {4'd0, acc_reg} * (VW+4)'(10) + (VW+4)'(word.digit);
    assign v      = acc_reg;

    // parse one word
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        tapes_next  = tapes_reg;
        rows_next   = rows_reg;
        states_next = states_reg;
        syms_next   = syms_reg;
        seen_next   = seen_reg;
        from_next   = from_reg;
        to_next     = to_reg;
        tape_next   = tape_reg;
        none_next   = none_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        r           = '0;
        emit        = 1'b0;
        is_err      = 1'b0;
        err         = ERR_MAGIC;
        do_clear    = 1'b0;
        is_term     = (f == F_SYMS) ? (word.cls == CLS_NEWLINE) : (word.cls == CLS_TAB);
        label       = '0;
        if (phase_reg < PH_NUM)
        begin
            if (word.cls == CLS_END || word.ch != magic_char(phase_reg[2:0]))
            begin
                is_err = 1'b1;
                err    = ERR_MAGIC;
            end
            else
                phase_next = phase_reg + 1'b1;
        end
        else if (phase_reg < PH_ROWFIRST)
        begin
            if (f == F_TAPE && first && word.cls == CLS_MINUS)
                phase_next = PH_MINUS1;
            else if (first)
            begin
                if (!is_dig)
                begin
                    is_err = 1'b1;
                    err    = ERR_MISSING;
                end
                else
                begin
                    acc_next = VW'(word.digit);
                    if ({28'd0, word.digit} >= 32'(FIELD_MAX))
                    begin
                        is_err = 1'b1;
                        err    = ERR_TOO_LARGE;
                    end
                    else
                        phase_next = phase_reg + 1'b1;
                end
            end
            else if (is_term)
            begin
                case (f)
                    F_TAPES:
                    begin
                        tapes_next = v;
                        phase_next = PH_NUM + 5'd2;
                    end
                    F_ROWS:
                    begin
                        rows_next  = v;
                        phase_next = PH_NUM + 5'd4;
                    end
                    F_STATES:
                    begin
                        states_next = v;
                        phase_next  = PH_NUM + 5'd6;
                    end
                    F_SYMS:
                    begin
                        syms_next       = v;
                        r.kind          = KIND_HEADER;
                        r.count_tapes   = 15'(tapes_reg);
                        r.count_rows    = 15'(rows_reg);
                        r.count_states  = 15'(states_reg);
                        r.count_symbols = 15'(v);
                        emit            = 1'b1;
                        seen_next       = '0;
                        phase_next      = PH_ROWFIRST;
                    end
                    F_FROM:
                    begin
                        if (v >= states_reg)
                        begin
                            is_err = 1'b1;
                            err    = ERR_STATE;
                        end
                        else
                        begin
                            from_next  = v;
                            phase_next = PH_NUM + 5'd10;
                        end
                    end
                    F_TO:
                    begin
                        if (v >= states_reg)
                        begin
                            is_err = 1'b1;
                            err    = ERR_STATE;
                        end
                        else
                        begin
                            to_next    = v;
                            phase_next = PH_NUM + 5'd12;
                        end
                    end
                    F_TAPE:
                    begin
                        if (v >= tapes_reg)
                        begin
                            is_err = 1'b1;
                            err    = ERR_TAPE;
                        end
                        else
                        begin
                            tape_next  = v;
                            none_next  = 1'b0;
                            phase_next = PH_NUM + 5'd14;
                        end
                    end
                    default:
                    begin
                        len_next   = v;
                        left_next  = v;
                        phase_next = (v != '0) ? PH_TOKEN : PH_NEWLINE;
                    end
                endcase
            end
            else if (!is_dig)
            begin
                is_err = 1'b1;
                err    = ERR_BAD_DIGIT;
            end
            else
            begin
                acc_next = VW'(prod);
                if (prod >= (VW+4)'(FIELD_MAX))
                begin
                    is_err = 1'b1;
                    err    = ERR_TOO_LARGE;
                end
            end
        end
        else if (phase_reg == PH_ROWFIRST || phase_reg == PH_ROWNEXT)
        begin
            if (phase_reg == PH_ROWNEXT && word.cls == CLS_END)
            begin
                r.kind   = KIND_DONE;
                emit     = 1'b1;
                do_clear = 1'b1;
            end
            else if (seen_reg >= rows_reg)
            begin
                is_err = 1'b1;
                err    = ERR_ROWS;
            end
            else
            begin
                seen_next = seen_reg + 1'b1;
                if (!is_dig)
                begin
                    is_err = 1'b1;
                    err    = ERR_MISSING;
                end
                else
                begin
                    acc_next = VW'(word.digit);
                    if ({28'd0, word.digit} >= 32'(FIELD_MAX))
                    begin
                        is_err = 1'b1;
                        err    = ERR_TOO_LARGE;
                    end
                    else
                        phase_next = PH_NUM + 5'd9;
                end
            end
        end
        else if (phase_reg == PH_MINUS1)
        begin
            if (word.cls == CLS_END || word.ch != CH_ONE)
            begin
                is_err = 1'b1;
                err    = ERR_MINUS;
            end
            else
                phase_next = PH_MINUSTAB;
        end
        else if (phase_reg == PH_MINUSTAB)
        begin
            if (word.cls != CLS_TAB)
            begin
                is_err = 1'b1;
                err    = ERR_MINUS_TAB;
            end
            else
            begin
                none_next  = 1'b1;
                phase_next = PH_NUM + 5'd14;
            end
        end
        else if (phase_reg == PH_TOKEN)
        begin
            if (word.cls == CLS_END)
            begin
                is_err = 1'b1;
                err    = ERR_END_TOKEN;
            end
            else
            begin
                r.kind       = KIND_TOKEN;
                r.token_byte = word.ch;
                emit         = 1'b1;
                left_next    = left_reg - 1'b1;
                if (left_reg == VW'(1))
                    phase_next = PH_NEWLINE;
            end
        end
        else if (phase_reg == PH_NEWLINE)
        begin
            if (word.cls != CLS_NEWLINE)
            begin
                is_err = 1'b1;
                err    = ERR_NEWLINE;
            end
            else if (none_reg && len_reg != '0)
            begin
                is_err = 1'b1;
                err    = ERR_EMPTY_TOK;
            end
            else
            begin
                if (!none_reg && len_reg == '0)
                    label = (to_reg == VW'(1)) ? 16'd1 : 16'(tapes_reg) + 16'(tape_reg);
                r.kind         = KIND_ROW;
                r.src_state    = 15'(from_reg);
                r.dst_state    = 15'(to_reg);
                r.tape_index   = none_reg ? 16'hffff : 16'(tape_reg);
                r.token_length = 15'(len_reg);
                r.label_value  = label;
                emit           = 1'b1;
                phase_next     = PH_ROWNEXT;
            end
        end
        else
        begin
            if (word.cls == CLS_END)
                do_clear = 1'b1;
        end

        if (is_err)
        begin
            r            = '0;
            r.kind       = KIND_ERROR;
            r.fault_code = err;
            emit         = 1'b1;
            if (word.cls == CLS_END)
                do_clear = 1'b1;
            else
                phase_next = PH_ABSORB;
        end

        if (do_clear)
        begin
            phase_next  = PH_MAGIC;
            acc_next    = '0;
            tapes_next  = '0;
            rows_next   = '0;
            states_next = '0;
            syms_next   = '0;
            seen_next   = '0;
            from_next   = '0;
            to_next     = '0;
            tape_next   = '0;
            none_next   = 1'b0;
            len_next    = '0;
            left_next   = '0;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            acc_reg    <= '0;
            tapes_reg  <= '0;
            rows_reg   <= '0;
            states_reg <= '0;
            syms_reg   <= '0;
            seen_reg   <= '0;
            from_reg   <= '0;
            to_reg     <= '0;
            tape_reg   <= '0;
            none_reg   <= 1'b0;
            len_reg    <= '0;
            left_reg   <= '0;
            full_reg   <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                tapes_reg  <= tapes_next;
                rows_reg   <= rows_next;
                states_reg <= states_next;
                syms_reg   <= syms_next;
                seen_reg   <= seen_next;
                from_reg   <= from_next;
                to_reg     <= to_next;
                tape_reg   <= tape_next;
                none_reg   <= none_next;
                len_reg    <= len_next;
                left_reg   <= left_next;
            end
            if (word_take)
                full_reg <= step && emit;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (step && emit)
            res_reg <= r;
    end

endmodule

// File: rtl/core/automaton_text_row_parser.sv
// Text-row automaton loader: parses the save text one character per word.
// Input channel: push/full with in_byte and is_end (is_end marks end of file).
// Result channel: empty/pop; the oldest result sits on the ports while empty
// is low. Results are header records, token bytes, row records, done and error.
// A word passes a two-entry classification queue and then the parser, which
// takes one word per cycle; a result is registered at the edge that accepts its
// word into the parser and can be popped at the next edge at the earliest.
// Sustained rate is one word per cycle while the result register is empty or
// popped, as the parser does the decimal accumulate combinationally.
// When the receiver stalls, the result register holds, the parser stops and
// the queue fills; full rises once the queue is full.
// After an error words are absorbed until end of file, which restarts parsing.
// Reset empties the queue and result register and waits for the magic word.
module automaton_text_row_parser
    import atrp_pkg::*;
#(
    parameter int FIELD_MAX = 32767
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        is_end,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  res_kind,
    output logic [14:0] count_tapes,
    output logic [14:0] count_rows,
    output logic [14:0] count_states,
    output logic [14:0] count_symbols,
    output logic [14:0] src_state,
    output logic [14:0] dst_state,
    output logic signed [15:0] tape_index,
    output logic [14:0] token_length,
    output logic [15:0] label_value,
    output logic [7:0]  token_byte,
    output logic [3:0]  fault_code
);

    logic         word_valid, word_take;
    atrp_word_t   word;
    atrp_result_t res;

    atrp_front #(.DEPTH(2)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .is_end     (is_end),
        .word_valid (word_valid),
        .word_take  (word_take),
        .word       (word)
    );

    atrp_back #(.FIELD_MAX(FIELD_MAX)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_take  (word_take),
        .word       (word),
        .empty      (empty),
        .pop        (pop),
        .res        (res)
    );

    // result fields
    assign res_kind      = res.kind;
    assign count_tapes   = res.count_tapes;
    assign count_rows    = res.count_rows;
    assign count_states  = res.count_states;
    assign count_symbols = res.count_symbols;
    assign src_state     = res.src_state;
    assign dst_state     = res.dst_state;
    assign tape_index    = res.tape_index;
    assign token_length  = res.token_length;
    assign label_value   = res.label_value;
    assign token_byte    = res.token_byte;
    assign fault_code    = res.fault_code;

endmodule

// File: tb/sv/atrp_checker.sv
`timescale 1ns / 1ps

module atrp_checker
    import atrp_pkg::*;
#(
    parameter int FIELD_MAX = 32767
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  in_byte,
    input  logic        is_end,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  res_kind,
    input  logic [14:0] count_tapes,
    input  logic [14:0] count_rows,
    input  logic [14:0] count_states,
    input  logic [14:0] count_symbols,
    input  logic [14:0] src_state,
    input  logic [14:0] dst_state,
    input  logic signed [15:0] tape_index,
    input  logic [14:0] token_length,
    input  logic [15:0] label_value,
    input  logic [7:0]  token_byte,
    input  logic [3:0]  fault_code,
    output int          fail_count,
    output int          pending,
    output int          rows_done,
    output int          errors_done,
    output int          files_done
);

    typedef enum int {
        PH_MAGIC, PH_FIELD, PH_ROW_FIRST, PH_ROW_NEXT, PH_MINUS_ONE,
        PH_MINUS_TAB, PH_TOKEN, PH_NEWLINE, PH_ABSORB
    } phase_e;

    localparam int FLD_TAPES  = 0;
    localparam int FLD_ROWS   = 1;
    localparam int FLD_STATES = 2;
    localparam int FLD_SYMS   = 3;
    localparam int FLD_FROM   = 4;
    localparam int FLD_TO     = 5;
    localparam int FLD_TAPE   = 6;
    localparam int FLD_LEN    = 7;
    localparam logic [15:0] TAPE_NONE = 16'hffff;

    atrp_result_t parsed_q[$];

    phase_e phase;
    int     magic_pos, field_idx;
    bit     field_first;
    int     accum, n_tapes, n_rows, n_states, n_syms, rows_seen;
    int     r_from, r_to, r_tape, r_len, tok_left;

    function automatic bit is_dig(int c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic clear_parse();
        phase = PH_MAGIC; magic_pos = 0; field_idx = 0; field_first = 1;
        accum = 0; n_tapes = 0; n_rows = 0; n_states = 0; n_syms = 0;
        rows_seen = 0; r_from = 0; r_to = 0; r_tape = 0; r_len = 0; tok_left = 0;
    endtask

    // end of a numeric field; returns error code or -1
    function automatic int close_field(ref atrp_result_t r, ref bit got);
        int v;
        v = accum;
        field_first = 1;
        case (field_idx)
            FLD_TAPES:  begin n_tapes = v; field_idx = FLD_ROWS; end
            FLD_ROWS:   begin n_rows = v; field_idx = FLD_STATES; end
            FLD_STATES: begin n_states = v; field_idx = FLD_SYMS; end
            FLD_SYMS:
            begin
                n_syms = v;
                r.kind = KIND_HEADER;
                r.count_tapes = n_tapes[14:0];
                r.count_rows = n_rows[14:0];
                r.count_states = n_states[14:0];
                r.count_symbols = n_syms[14:0];
                got = 1;
                rows_seen = 0;
                phase = PH_ROW_FIRST;
            end
            FLD_FROM:
            begin
                if (v >= n_states) return ERR_STATE;
                r_from = v; field_idx = FLD_TO;
            end
            FLD_TO:
            begin
                if (v >= n_states) return ERR_STATE;
                r_to = v; field_idx = FLD_TAPE;
            end
            FLD_TAPE:
            begin
                if (v >= n_tapes) return ERR_TAPE;
                r_tape = v; field_idx = FLD_LEN;
            end
            default:
            begin
                r_len = v; tok_left = v;
                phase = (v != 0) ? PH_TOKEN : PH_NEWLINE;
            end
        endcase
        return -1;
    endfunction

    function automatic int field_char(int c, ref atrp_result_t r, ref bit got);
        int term;
        term = (field_idx == FLD_SYMS) ? CH_NEWLINE : CH_TAB;
        if (field_first)
        begin
            if (!is_dig(c)) return ERR_MISSING;
            accum = c - CH_ZERO;
            if (accum >= FIELD_MAX) return ERR_TOO_LARGE;
            field_first = 0;
            phase = PH_FIELD;
            return -1;
        end
        if (c == term) return close_field(r, got);
        if (!is_dig(c)) return ERR_BAD_DIGIT;
        accum = accum * 10 + (c - CH_ZERO);
        if (accum >= FIELD_MAX) return ERR_TOO_LARGE;
        return -1;
    endfunction

    // predict the result of one accepted word
    task automatic parse_word(logic [7:0] b, logic e);
        atrp_result_t r;
        bit got;
        int c, err, lbl;
        r = '0; got = 0; err = -1;
        c = e ? 256 : int'(b);
        case (phase)
            PH_MAGIC:
            begin
                if (c != magic_char(magic_pos[2:0])) err = ERR_MAGIC;
                else if (magic_pos == MAGIC_LEN - 1)
                begin
                    phase = PH_FIELD; field_idx = FLD_TAPES; field_first = 1;
                end
                else magic_pos++;
            end
            PH_FIELD:
            begin
                if (field_idx == FLD_TAPE && field_first && c == CH_MINUS)
                    phase = PH_MINUS_ONE;
                else err = field_char(c, r, got);
            end
            PH_ROW_FIRST, PH_ROW_NEXT:
            begin
                if (phase == PH_ROW_NEXT && e)
                begin
                    r.kind = KIND_DONE;
                    parsed_q.push_back(r);
                    files_done++;
                    clear_parse();
                    return;
                end
                if (rows_seen >= n_rows) err = ERR_ROWS;
                else
                begin
                    rows_seen++;
                    field_idx = FLD_FROM; field_first = 1;
                    err = field_char(c, r, got);
                end
            end
            PH_MINUS_ONE:
            begin
                if (c != CH_ONE) err = ERR_MINUS;
                else phase = PH_MINUS_TAB;
            end
            PH_MINUS_TAB:
            begin
                if (c != CH_TAB) err = ERR_MINUS_TAB;
                else
                begin
                    r_tape = TAPE_NONE; phase = PH_FIELD;
                    field_idx = FLD_LEN; field_first = 1;
                end
            end
            PH_TOKEN:
            begin
                if (e) err = ERR_END_TOKEN;
                else
                begin
                    r.kind = KIND_TOKEN; r.token_byte = b; got = 1;
                    if (tok_left != 0) tok_left--;
                    if (tok_left == 0) phase = PH_NEWLINE;
                end
            end
            PH_NEWLINE:
            begin
                if (c != CH_NEWLINE) err = ERR_NEWLINE;
                else if (r_tape == TAPE_NONE && r_len != 0) err = ERR_EMPTY_TOK;
                else
                begin
                    lbl = 0;
                    if (r_tape != TAPE_NONE && r_len == 0)
                        lbl = (r_to == 1) ? 1 : n_tapes + r_tape;
                    r.kind = KIND_ROW;
                    r.src_state = r_from[14:0];
                    r.dst_state = r_to[14:0];
                    r.tape_index = r_tape[15:0];
                    r.token_length = r_len[14:0];
                    r.label_value = lbl[15:0];
                    got = 1;
                    rows_done++;
                    phase = PH_ROW_NEXT;
                end
            end
            default:
            begin
                if (e) clear_parse();
                return;
            end
        endcase
        if (err >= 0)
        begin
            r = '0;
            r.kind = KIND_ERROR;
            r.fault_code = err[3:0];
            got = 1;
            errors_done++;
            if (e) clear_parse();
            else phase = PH_ABSORB;
        end
        if (got) parsed_q.push_back(r);
    endtask

    task automatic report(string name, int exp_v, int act_v);
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
        fail_count++;
    endtask

    // compare one popped word with the oldest prediction
    task automatic compare_word();
        atrp_result_t x;
        if (parsed_q.size() == 0)
        begin
            $display("%0t unexpected result kind %0d: expected none", $time, res_kind);
            fail_count++;
            return;
        end
        x = parsed_q.pop_front();
        if (res_kind != x.kind) report("res_kind", x.kind, res_kind);
        if (count_tapes != x.count_tapes) report("count_tapes", x.count_tapes, count_tapes);
        if (count_rows != x.count_rows) report("count_rows", x.count_rows, count_rows);
        if (count_states != x.count_states)
            report("count_states", x.count_states, count_states);
        if (count_symbols != x.count_symbols)
            report("count_symbols", x.count_symbols, count_symbols);
        if (src_state != x.src_state) report("src_state", x.src_state, src_state);
        if (dst_state != x.dst_state) report("dst_state", x.dst_state, dst_state);
        if (tape_index != x.tape_index) report("tape_index", x.tape_index, tape_index);
        if (token_length != x.token_length)
            report("token_length", x.token_length, token_length);
        if (label_value != x.label_value) report("label_value", x.label_value, label_value);
        if (token_byte != x.token_byte) report("token_byte", x.token_byte, token_byte);
        if (fault_code != x.fault_code) report("fault_code", x.fault_code, fault_code);
    endtask

    initial
    begin
        fail_count = 0; rows_done = 0; errors_done = 0; files_done = 0; pending = 0;
        clear_parse();
    end

    // watch both channels at every edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty) compare_word();
            if (push && !full) parse_word(in_byte, is_end);
        end
        pending = parsed_q.size();
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import atrp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_GOAL = 1850;

    logic clk, rst_n, push, full, is_end, empty, pop;
    logic [7:0] in_byte;
    logic [2:0] res_kind;
    logic [14:0] count_tapes, count_rows, count_states, count_symbols;
    logic [14:0] src_state, dst_state, token_length;
    logic signed [15:0] tape_index;
    logic [15:0] label_value;
    logic [7:0] token_byte;
    logic [3:0] fault_code;
    int fail_count, pending, rows_done, errors_done, files_done;

    int send_idle, recv_idle, words_sent, idle_cycles;
    bit hold_off, stim_done, timed_out;

    automaton_text_row_parser uut (.*);
    atrp_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // push one word, idling at random beforehand
    task automatic send_word(logic [7:0] b, logic e);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1; in_byte <= b; is_end <= e;
        @(posedge clk);
        while (full) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    endtask

    task automatic send_num(int v);
        send_text($sformatf("%0d", v));
    endtask

    // first n characters of the magic word, which ends in its tab
    task automatic send_magic(int n);
        for (int i = 0; i < n; i++) send_word(magic_char(3'(i)), 1'b0);
    endtask

    // one row; tape -1 is the empty move
    task automatic send_row(int f, int t, int tp, int len);
        send_num(f); send_word(CH_TAB, 1'b0);
        send_num(t); send_word(CH_TAB, 1'b0);
        if (tp < 0) send_text("-1"); else send_num(tp);
        send_word(CH_TAB, 1'b0);
        send_num(len); send_word(CH_TAB, 1'b0);
        for (int i = 0; i < len; i++) send_word(8'($urandom_range(255)), 1'b0);
        send_word(CH_NEWLINE, 1'b0);
    endtask

    task automatic send_header(int tp, int rw, int st, int sy);
        send_magic(MAGIC_LEN);
        send_num(tp); send_word(CH_TAB, 1'b0);
        send_num(rw); send_word(CH_TAB, 1'b0);
        send_num(st); send_word(CH_TAB, 1'b0);
        send_num(sy); send_word(CH_NEWLINE, 1'b0);
    endtask

    task automatic send_eof();
        send_word(8'($urandom_range(255)), 1'b1);
    endtask

    // a random file, mostly well formed, now and then with a corrupt word
    task automatic send_file();
        int tp, rw, st, n, tape, len, corrupt;
        tp = $urandom_range(1, 5);
        rw = $urandom_range(1, 8);
        st = $urandom_range(2, 10);
        corrupt = $urandom_range(9);
        send_header(tp, rw, st, $urandom_range(300));
        n = $urandom_range(1, rw + (corrupt == 0 ? 1 : 0));
        for (int i = 0; i < n; i++)
        begin
            tape = ($urandom_range(3) == 0) ? -1 : $urandom_range(tp - 1);
            len = (tape < 0 || $urandom_range(1)) ? 0 : $urandom_range(1, 3);
            if (corrupt == 1 && i == n - 1)
            begin
                send_word(8'($urandom_range(255)), 1'b0);
                send_word(8'($urandom_range(255)), 1'b0);
            end
            else if (corrupt == 2 && i == n - 1)
                send_row($urandom_range(st + 1), $urandom_range(st + 1),
                         $urandom_range(tp), $urandom_range(2));
            else
                send_row($urandom_range(st - 1), $urandom_range(st - 1), tape, len);
        end
        if (corrupt == 3) send_word(8'($urandom_range(255)), 1'b0);
        send_eof();
    endtask

    // long receiver hold-off while the sender keeps going
    initial
    begin
        hold_off = 0;
        wait (words_sent > 200);
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    // watchdog on accepted words
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        idle_cycles = 0;
        timed_out = 0;
        wait (idle_cycles >= WATCHDOG_LIMIT);
        timed_out = 1;
    end

    // stimulus
    initial
    begin
        rst_n = 0; push = 0; in_byte = 0; is_end = 0;
        send_idle = 31; recv_idle = 73; words_sent = 0; stim_done = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, minus forms, label cases, every error but ERR_TAPE
        send_header(3, 6, 32766, 0);
        send_row(32765, 1, 2, 0);
        send_row(0, 5, -1, 0);
        send_row(4, 7, 2, 2);
        send_row(1, 32766, 0, 0);
        send_eof();
        send_header(0, 0, 1, 9); send_eof();
        send_header(1, 0, 1, 1); send_word(CH_ZERO, 1'b0); send_eof();
        send_magic(5); send_text("X"); send_eof();
        send_magic(3); send_eof();
        send_magic(MAGIC_LEN); send_text("\t"); send_eof();
        send_magic(MAGIC_LEN); send_text("3a"); send_eof();
        send_magic(MAGIC_LEN); send_text("32767"); send_eof();
        send_magic(MAGIC_LEN); send_text("9\t9\t9\t9\n0\t0\t-2"); send_eof();
        send_magic(MAGIC_LEN); send_text("9\t9\t9\t9\n0\t0\t-1x"); send_eof();
        send_magic(MAGIC_LEN); send_text("9\t9\t9\t9\n0\t0\t-1\t2\tz"); send_eof();
        send_magic(MAGIC_LEN); send_text("9\t9\t9\t9\n0\t0\t-1\t2\tzz\n"); send_eof();
        send_magic(MAGIC_LEN); send_text("9\t9\t9\t9\n0\t0\t1\t0\tq"); send_eof();
        send_magic(MAGIC_LEN); send_text("9\t9\t9\t9\n"); send_eof();
        send_magic(MAGIC_LEN); send_text("9\t9\t9\t9\n");
        send_word(8'hff, 1'b0); send_eof();

        // random phases: idling swaps, then none
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 31 : (ph == 1) ? 73 : 0;
            recv_idle = (ph == 0) ? 73 : (ph == 1) ? 31 : 0;
            while (words_sent < ITEM_GOAL * (ph + 1) / 3)
            begin
                if ($urandom_range(9) == 0)
                begin
                    for (int i = $urandom_range(1, 6); i > 0; i--)
                        send_word(8'($urandom_range(255)), $urandom_range(7) == 0);
                    send_eof();
                end
                else
                    send_file();
            end
            if (ph < 2)
            begin
                push <= 1'b0;
                @(posedge clk);
                while (pending != 0 && !timed_out) @(posedge clk);
            end
        end
        push <= 1'b0;
        stim_done = 1;
    end

    // verdict
    initial
    begin
        wait ((stim_done && pending == 0) || timed_out);
        if (!timed_out) repeat (10) @(posedge clk);
        $display("sent %0d words: %0d rows, %0d errors, %0d complete files",
                 words_sent, rows_done, errors_done, files_done);
        if (timed_out)
            $display("Regression FAIL");
        else if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/atrp_pkg.sv
rtl/core/atrp_front.sv
rtl/core/atrp_back.sv
rtl/core/automaton_text_row_parser.sv
tb/sv/atrp_checker.sv
tb/sv/tb_top.sv
